FILE: hw/rtl/quadrature_speed_estimator_top_assert.svh
// Assertion macros for the quadrature speed estimator checker.
`ifndef QUADRATURE_SPEED_ESTIMATOR_TOP_ASSERT_SVH
`define QUADRATURE_SPEED_ESTIMATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qse checker: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define QSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qse checker: property failed");

`endif

FILE: hw/rtl/qse_pkg.sv
// Shared constants of the quadrature speed estimator.
`timescale 1ns / 1ps

package qse_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_COUNTER_PERIOD = 3'd0;
    localparam logic [2:0] CFG_REVERSE_DIR    = 3'd1;
    localparam logic [2:0] CFG_ENCODER_LINES  = 3'd2;
    localparam logic [2:0] CFG_GEAR_RATIO     = 3'd3;
    localparam logic [2:0] CFG_EDGE_MODE      = 3'd4;
    localparam logic [2:0] CFG_SAMPLE_MS      = 3'd5;
    localparam logic [2:0] CFG_MAX_STEP       = 3'd6;
    localparam logic [2:0] CFG_FILTER_ALPHA   = 3'd7;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 33;

    // Channel widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 128;

    // Reset values of the registers
    localparam logic [32:0] PERIOD_RST = 33'd65536;
    localparam logic [15:0] SAMPLE_MS_RST = 16'd10;
    localparam logic [16:0] ALPHA_ONE = 17'd65536;

    // 60000 ms/min times 256 sub-rpm steps
    localparam logic signed [24:0] SPEED_SCALE = 25'sd15360000;

endpackage

FILE: hw/rtl/quadrature_speed_estimator_top.sv
// Quadrature encoder speed estimator: fold, total, divide, slew limit, EMA.
`timescale 1ns / 1ps

//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------------
//  s_       | in  | s_tvalid/tready  | tuser: req_type; tdata: counter_value
//  m_       | out | m_tvalid/tready  | tuser: updated; tdata: delta, total,
//           |     |                  |        raw_speed, filtered_speed
//  cfg_     | in  | cfg_wr_en        | cfg_addr register index, cfg_wr_data
//
//  From accept to the next accept, a sample request runs through fold and
//  total, four passes of the shared 36x25 multiplier for the numerator and
//  the divisor, 32 steps of the restoring divider (one quotient bit a cycle),
//  then saturation, slew limit, EMA multiply, sum and rounding.
//  Reset requests and samples with a disabled setting skip to the output stage.
//  aresetn is synchronous, active low; it resets config, state and m_tvalid.
//  The result sits in an output register, so a new request is taken while an
//  earlier result still waits for m_tready.

module quadrature_speed_estimator_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [qse_pkg::IN_TDATA_W-1:0]     s_tdata,   // [31:0] counter_value
    input  logic [0:0]                         s_tuser,   // [0] req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] delta_count, [63:32] total_count, [95:64] raw_speed,
    // [127:96] filtered_speed
    output logic [qse_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [0:0]                         m_tuser,   // [0] updated
    input  logic                               cfg_wr_en,
    input  logic [qse_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [qse_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FOLD  = 4'd1;
    localparam logic [3:0] ST_MNUM  = 4'd2;
    localparam logic [3:0] ST_MD1   = 4'd3;
    localparam logic [3:0] ST_MD2   = 4'd4;
    localparam logic [3:0] ST_MD3   = 4'd5;
    localparam logic [3:0] ST_DINIT = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_SAT   = 4'd8;
    localparam logic [3:0] ST_SLEW  = 4'd9;
    localparam logic [3:0] ST_EMA   = 4'd10;
    localparam logic [3:0] ST_SUM   = 4'd11;
    localparam logic [3:0] ST_ROUND = 4'd12;
    localparam logic [3:0] ST_DONE  = 4'd13;

    logic [3:0] state_reg, state_next;

    // Configuration registers
    logic [32:0] period_reg;
    logic        reverse_reg;
    logic [15:0] lines_reg;
    logic [15:0] ratio_reg;
    logic [2:0]  mode_reg;
    logic [15:0] ms_reg;
    logic [30:0] max_step_reg;
    logic [16:0] alpha_reg;

    // Model state
    logic [31:0] prev_reg;
    logic [31:0] total_reg;
    logic [31:0] est_reg;

    // Working registers
    logic [31:0] cur_reg;
    logic [31:0] du_reg;
    logic [60:0] prod_reg;
    logic [54:0] num_mag_reg;
    logic        num_neg_reg;
    logic [50:0] den_reg;
    logic [50:0] rem_reg;
    logic [31:0] quo_reg;
    logic        sat_reg;
    logic [4:0]  bit_cnt_reg;
    logic [31:0] q_reg;
    logic [31:0] raw_reg;
    logic signed [50:0] sum_reg;
    logic        upd_reg;

    // Output register
    logic                              m_tvalid_reg;
    logic [qse_pkg::OUT_TDATA_W-1:0]   m_tdata_reg;
    logic                              m_tuser_reg;

    logic disabled;
    logic out_free;

    // Fold
    logic [31:0]        d32;
    logic signed [33:0] d34, half34, per34, f34;
    logic [31:0]        du_fold;

    // Shared multiplier
    logic signed [35:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [60:0] mul_p;

    // Divider step
    logic [55:0] num_abs;
    logic [31:0] num_lo;
    logic [51:0] trial;
    logic        trial_ge;
    logic [51:0] trial_sub;

    // Saturation, slew, EMA
    logic [31:0]        q_sat;
    logic signed [32:0] q33, e33, r33, diff33, lim33, dr33;
    logic [31:0]        raw_lim;
    logic [16:0]        alpha_eff;
    logic signed [50:0] sum_calc;
    logic [50:0]        sum_mag;
    logic [50:0]        sum_rnd;
    logic [31:0]        filt;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign disabled = (lines_reg == 16'd0) || (ratio_reg == 16'd0) ||
                      (mode_reg == 3'd0) || (ms_reg == 16'd0);

    // Fold the wrapped difference into [-period/2, period/2]
    always_comb begin
        d32    = cur_reg - prev_reg;
        d34    = {{2{d32[31]}}, d32};
        half34 = {2'b00, period_reg[32:1]};
        per34  = {1'b0, period_reg};
        if (d34 > half34) begin
            f34 = d34 - per34;
        end else if (d34 < -half34) begin
            f34 = d34 + per34;
        end else begin
            f34 = d34;
        end
        du_fold = reverse_reg ? (32'd0 - f34[31:0]) : f34[31:0];
    end

    // Operand selection for the shared multiplier
    always_comb begin
        r33  = {raw_reg[31], raw_reg};
        e33  = {est_reg[31], est_reg};
        dr33 = r33 - e33;
        alpha_eff = (alpha_reg > qse_pkg::ALPHA_ONE) ? qse_pkg::ALPHA_ONE : alpha_reg;
        unique case (state_reg)
            ST_MNUM: begin
                mul_a = {{4{du_reg[31]}}, du_reg};
                mul_b = qse_pkg::SPEED_SCALE;
            end
            ST_MD1: begin
                mul_a = {20'd0, lines_reg};
                mul_b = {9'd0, ratio_reg};
            end
            ST_MD2: begin
                mul_a = {4'd0, prod_reg[31:0]};
                mul_b = {22'd0, mode_reg};
            end
            ST_MD3: begin
                mul_a = {1'b0, prod_reg[34:0]};
                mul_b = {9'd0, ms_reg};
            end
            ST_EMA: begin
                mul_a = {{3{dr33[32]}}, dr33};
                mul_b = {8'd0, alpha_eff};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Numerator magnitude and one restoring-division step
    always_comb begin
        num_abs   = prod_reg[55] ? (56'd0 - prod_reg[55:0]) : prod_reg[55:0];
        num_lo    = num_mag_reg[31:0];
        trial     = {rem_reg, num_lo[bit_cnt_reg]};
        trial_ge  = (trial >= {1'b0, den_reg});
        trial_sub = trial - {1'b0, den_reg};
    end

    // Saturate the signed quotient to 32 bits
    always_comb begin
        if (num_neg_reg) begin
            q_sat = (sat_reg || (quo_reg > 32'h8000_0000)) ? 32'h8000_0000
                                                           : (32'd0 - quo_reg);
        end else begin
            q_sat = (sat_reg || quo_reg[31]) ? 32'h7FFF_FFFF : quo_reg;
        end
    end

    // Slew limit against the filtered speed
    always_comb begin
        q33    = {q_reg[31], q_reg};
        diff33 = q33 - e33;
        lim33  = {2'b00, max_step_reg};
        raw_lim = q_reg;
        if (max_step_reg != 31'd0) begin
            if (diff33 > lim33) begin
                raw_lim = 32'(e33 + lim33);
            end else if (diff33 < -lim33) begin
                raw_lim = 32'(e33 - lim33);
            end
        end
    end

    // EMA: est*65536 + alpha*(raw - est), rounded half away from zero
    always_comb begin
        sum_calc = $signed(prod_reg[50:0]) + $signed({{3{est_reg[31]}}, est_reg, 16'd0});
        sum_mag  = sum_reg[50] ? (51'd0 - 51'(sum_reg)) : 51'(sum_reg);
        sum_rnd  = sum_mag + 51'd32768;
        filt     = sum_reg[50] ? (32'd0 - sum_rnd[47:16]) : sum_rnd[47:16];
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser[0] || disabled) ? ST_DONE : ST_FOLD;
                end
            end
            ST_FOLD:  state_next = ST_MNUM;
            ST_MNUM:  state_next = ST_MD1;
            ST_MD1:   state_next = ST_MD2;
            ST_MD2:   state_next = ST_MD3;
            ST_MD3:   state_next = ST_DINIT;
            ST_DINIT: state_next = ST_DIV;
            ST_DIV: begin
                if (bit_cnt_reg == 5'd0) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:   state_next = ST_SLEW;
            ST_SLEW:  state_next = ST_EMA;
            ST_EMA:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_ROUND;
            ST_ROUND: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and estimator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            period_reg   <= qse_pkg::PERIOD_RST;
            reverse_reg  <= 1'b0;
            lines_reg    <= '0;
            ratio_reg    <= '0;
            mode_reg     <= '0;
            ms_reg       <= qse_pkg::SAMPLE_MS_RST;
            max_step_reg <= '0;
            alpha_reg    <= qse_pkg::ALPHA_ONE;
            prev_reg     <= '0;
            total_reg    <= '0;
            est_reg      <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    qse_pkg::CFG_COUNTER_PERIOD: period_reg   <= cfg_wr_data;
                    qse_pkg::CFG_REVERSE_DIR:    reverse_reg  <= cfg_wr_data[0];
                    qse_pkg::CFG_ENCODER_LINES:  lines_reg    <= cfg_wr_data[15:0];
                    qse_pkg::CFG_GEAR_RATIO:     ratio_reg    <= cfg_wr_data[15:0];
                    qse_pkg::CFG_EDGE_MODE:      mode_reg     <= cfg_wr_data[2:0];
                    qse_pkg::CFG_SAMPLE_MS:      ms_reg       <= cfg_wr_data[15:0];
                    qse_pkg::CFG_MAX_STEP:       max_step_reg <= cfg_wr_data[30:0];
                    qse_pkg::CFG_FILTER_ALPHA:   alpha_reg    <= cfg_wr_data[16:0];
                    default: ;
                endcase
            end

            if (state_reg == ST_IDLE && s_tvalid && s_tuser[0]) begin
                prev_reg  <= '0;
                total_reg <= '0;
                est_reg   <= '0;
            end
            if (state_reg == ST_FOLD) begin
                prev_reg  <= cur_reg;
                total_reg <= total_reg + du_fold;
            end
            if (state_reg == ST_ROUND) begin
                est_reg <= filt;
            end

            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        unique case (state_reg)
            ST_IDLE: begin
                cur_reg <= s_tdata;
                du_reg  <= '0;
                raw_reg <= '0;
                upd_reg <= 1'b0;
            end
            ST_FOLD: begin
                du_reg <= du_fold;
            end
            ST_MD1: begin
                num_mag_reg <= num_abs[54:0];
                num_neg_reg <= prod_reg[55];
            end
            ST_DINIT: begin
                den_reg     <= prod_reg[50:0];
                sat_reg     <= ({28'd0, num_mag_reg[54:32]} >= prod_reg[50:0]);
                rem_reg     <= {28'd0, num_mag_reg[54:32]};
                quo_reg     <= '0;
                bit_cnt_reg <= 5'd31;
            end
            ST_DIV: begin
                rem_reg     <= trial_ge ? trial_sub[50:0] : trial[50:0];
                quo_reg     <= {quo_reg[30:0], trial_ge};
                bit_cnt_reg <= bit_cnt_reg - 5'd1;
            end
            ST_SAT: begin
                q_reg <= q_sat;
            end
            ST_SLEW: begin
                raw_reg <= raw_lim;
            end
            ST_SUM: begin
                sum_reg <= sum_calc;
            end
            ST_ROUND: begin
                upd_reg <= 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= {est_reg, raw_reg, total_reg, du_reg};
                    m_tuser_reg <= upd_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/qse_checker.sv
// Port-level checker for the quadrature speed estimator, bound to the top level.
`timescale 1ns / 1ps
`include "quadrature_speed_estimator_top_assert.svh"

module qse_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [qse_pkg::IN_TDATA_W-1:0]     s_tdata,
    input logic [0:0]                         s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [qse_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input logic [0:0]                         m_tuser,
    input logic                               cfg_wr_en,
    input logic [qse_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input logic [qse_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    // the block is not ready in the cycle after it accepts a request
    `QSE_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // a result that is not taken stays put
    `QSE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // reset or ignored samples report no difference and no raw speed
    `QSE_ASSERT_IMP(a_idle_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[31:0] == 32'd0 && m_tdata[95:64] == 32'd0)

endmodule

bind quadrature_speed_estimator_top qse_checker u_qse_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for the quadrature speed estimator top level.
`timescale 1ns / 1ps

module tb_top;

    import qse_pkg::*;

    // Request kinds carried on s_tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    localparam int IDLE_PCT     = 14;
    // Margin kept after the last result before the summary is printed.
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 135;

    // Timeout for the whole run of about 1130 requests, slowed by sender gaps and
    // sink stalls.
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef struct packed {
        logic        updated;
        logic [31:0] delta;
        logic [31:0] total;
        logic [31:0] raw;
        logic [31:0] filt;
    } speed_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;    // [31:0] counter_value
    logic [0:0]             s_tuser = '0;    // [0] req_type
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // delta, total, raw, filtered (low to high)
    logic [0:0]             m_tuser;         // [0] updated
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    quadrature_speed_estimator_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // Shadow copy of the block's registers
    logic [32:0] period_sh;
    logic        reverse_sh;
    logic [15:0] lines_sh;
    logic [15:0] ratio_sh;
    logic [2:0]  edges_sh;
    logic [15:0] sample_ms_sh;
    logic [30:0] max_step_sh;
    logic [16:0] alpha_sh;

    // Shadow copy of the block's state
    logic [31:0]        last_count;
    logic [31:0]        pos_total;
    logic signed [31:0] speed_est;

    speed_result_t pending_results[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int requests_sent = 0;
    int clears_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int settings_used = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Sink side: random back-pressure, one decision per cycle
    initial begin
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d requests still waiting for a result", pending_results.size());
        $display("status: fail");
        $finish;
    end

    //----------------------------------------------------------------------------------------
    // Predictor
    //----------------------------------------------------------------------------------------

    function automatic speed_result_t predict_speed(input logic kind, input logic [31:0] cnt);
        speed_result_t r;
        longint        d, half, per, num, den, q, diff, lim, a, sum, mag;
        logic [31:0]   du;
        r = '0;
        if (kind == REQ_CLEAR) begin
            last_count = '0;
            pos_total  = '0;
            speed_est  = '0;
            return r;
        end
        // any zero in the scale disables the update
        if (lines_sh == 0 || ratio_sh == 0 || edges_sh == 0 || sample_ms_sh == 0) begin
            r.total = pos_total;
            r.filt  = speed_est;
            return r;
        end

        // fold the wrapped difference into [-period/2, period/2]
        d    = longint'($signed(cnt - last_count));
        per  = longint'(period_sh);
        half = longint'(period_sh >> 1);
        if (d > half)
            d = d - per;
        else if (d < -half)
            d = d + per;
        du = d[31:0];
        if (reverse_sh)
            du = 32'd0 - du;
        pos_total  = pos_total + du;
        last_count = cnt;

        num = longint'($signed(du)) * longint'(SPEED_SCALE);
        den = longint'(lines_sh) * longint'(ratio_sh) * longint'(edges_sh)
            * longint'(sample_ms_sh);
        q = num / den;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;

        // slew limit relative to the filtered speed
        if (max_step_sh != 0) begin
            lim  = longint'(max_step_sh);
            diff = q - longint'(speed_est);
            if (diff > lim)
                q = longint'(speed_est) + lim;
            else if (diff < -lim)
                q = longint'(speed_est) - lim;
        end

        a   = (alpha_sh > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_sh);
        sum = a * q + (longint'(ALPHA_ONE) - a) * longint'(speed_est);
        // round half away from zero
        if (sum < 0) begin
            mag = (-sum + 32768) >>> 16;
            mag = -mag;
        end else begin
            mag = (sum + 32768) >>> 16;
        end
        speed_est = mag[31:0];

        r.updated = 1'b1;
        r.delta   = du;
        r.total   = pos_total;
        r.raw     = q[31:0];
        r.filt    = speed_est;
        return r;
    endfunction

    //----------------------------------------------------------------------------------------
    // Stimulus primitives
    //----------------------------------------------------------------------------------------

    // Send one request, with random gaps ahead of it; s_tvalid stays high on return
    // so the next request can follow back to back.
    task automatic send_request(input logic kind, input logic [31:0] cnt);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= cnt;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_speed(kind, cnt));
        requests_sent++;
        if (kind == REQ_CLEAR)
            clears_sent++;
    endtask

    // Stop the stream and wait until every result is back.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    // Register write; only ever issued with the block idle.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [32:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            CFG_COUNTER_PERIOD: period_sh    = value;
            CFG_REVERSE_DIR:    reverse_sh   = value[0];
            CFG_ENCODER_LINES:  lines_sh     = value[15:0];
            CFG_GEAR_RATIO:     ratio_sh     = value[15:0];
            CFG_EDGE_MODE:      edges_sh     = value[2:0];
            CFG_SAMPLE_MS:      sample_ms_sh = value[15:0];
            CFG_MAX_STEP:       max_step_sh  = value[30:0];
            CFG_FILTER_ALPHA:   alpha_sh     = value[16:0];
            default: ;
        endcase
    endtask

    task automatic write_setup(input logic [32:0] per, input logic rev, input int lines,
                               input int ratio, input int edges, input int ms,
                               input logic [30:0] step, input logic [16:0] alpha);
        write_reg(CFG_COUNTER_PERIOD, per);
        write_reg(CFG_REVERSE_DIR,    33'(rev));
        write_reg(CFG_ENCODER_LINES,  33'(lines));
        write_reg(CFG_GEAR_RATIO,     33'(ratio));
        write_reg(CFG_EDGE_MODE,      33'(edges));
        write_reg(CFG_SAMPLE_MS,      33'(ms));
        write_reg(CFG_MAX_STEP,       33'(step));
        write_reg(CFG_FILTER_ALPHA,   33'(alpha));
        settings_used++;
    endtask

    //----------------------------------------------------------------------------------------
    // Result checker
    //----------------------------------------------------------------------------------------

    always @(posedge aclk) begin
        speed_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.updated = m_tuser[0];
            got.delta   = m_tdata[31:0];
            got.total   = m_tdata[63:32];
            got.raw     = m_tdata[95:64];
            got.filt    = m_tdata[127:96];
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result #%0d: upd=%0d delta=%0d total=%0d raw=%0d filt=%0d",
                             results_seen, got.updated, $signed(got.delta),
                             $signed(got.total), $signed(got.raw), $signed(got.filt));
            end else begin
                want = pending_results.pop_front();
                if (got.updated !== want.updated || got.delta !== want.delta ||
                    got.total !== want.total || got.raw !== want.raw ||
                    got.filt !== want.filt) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch on result #%0d", results_seen);
                        $display("  expected upd=%0d delta=%0d total=%0d raw=%0d filt=%0d",
                                 want.updated, $signed(want.delta), $signed(want.total),
                                 $signed(want.raw), $signed(want.filt));
                        $display("  actual   upd=%0d delta=%0d total=%0d raw=%0d filt=%0d",
                                 got.updated, $signed(got.delta), $signed(got.total),
                                 $signed(got.raw), $signed(got.filt));
                    end
                end
            end
        end
    end

    //----------------------------------------------------------------------------------------
    // Tests
    //----------------------------------------------------------------------------------------

    // Register reset values leave the scale at zero, so samples are ignored.
    task automatic test_reset_defaults();
        send_request(REQ_SAMPLE, 32'd1234);
        send_request(REQ_SAMPLE, 32'hFFFF_FFFF);
        send_request(REQ_CLEAR,  32'hFFFF_FFFF);
    endtask

    // Folding around the half period, a count above the period, and reverse.
    task automatic test_count_folding();
        write_setup(33'd65536, 1'b0, 1000, 1, 4, 10, 31'd0, 17'd65536);
        send_request(REQ_SAMPLE, 32'd100);
        send_request(REQ_SAMPLE, 32'd65500);   // backward across the wrap
        send_request(REQ_SAMPLE, 32'd32732);   // exactly minus half, kept
        send_request(REQ_SAMPLE, 32'd0);
        send_request(REQ_SAMPLE, 32'd32768);   // exactly plus half, kept
        send_request(REQ_SAMPLE, 32'd70000);   // count at or above the period
        write_reg(CFG_REVERSE_DIR, 33'd1);
        send_request(REQ_SAMPLE, 32'd40000);
        send_request(REQ_CLEAR,  32'd0);
    endtask

    // Degenerate and full-width periods, reverse of the most negative difference.
    task automatic test_odd_periods();
        write_reg(CFG_COUNTER_PERIOD, 33'd0);
        send_request(REQ_SAMPLE, 32'h8000_0000);   // reversed -2^31 wraps to itself
        write_reg(CFG_REVERSE_DIR, 33'd0);
        write_reg(CFG_COUNTER_PERIOD, 33'd1);
        send_request(REQ_SAMPLE, 32'h8000_0005);
        send_request(REQ_SAMPLE, 32'h8000_0001);
        write_reg(CFG_COUNTER_PERIOD, 33'h1_0000_0000);
        send_request(REQ_SAMPLE, 32'h0000_0001);
        send_request(REQ_SAMPLE, 32'h8000_0001);   // -2^31 stays unfolded
    endtask

    // Saturation of the quotient, slew limit and filter weights.
    task automatic test_speed_limits();
        write_setup(33'h1_0000_0000, 1'b0, 1, 1, 1, 1, 31'd0, 17'd65536);
        send_request(REQ_CLEAR,  32'd0);
        send_request(REQ_SAMPLE, 32'h7FFF_FFFF);   // saturates high
        send_request(REQ_SAMPLE, 32'd0);           // saturates low
        write_reg(CFG_MAX_STEP, 33'd1000);
        write_reg(CFG_FILTER_ALPHA, 33'd131071);   // weight above one, clamped
        send_request(REQ_SAMPLE, 32'd500);
        write_reg(CFG_FILTER_ALPHA, 33'd0);
        write_reg(CFG_MAX_STEP, 33'h7FFF_FFFF);
        send_request(REQ_SAMPLE, 32'd2000);
        write_reg(CFG_FILTER_ALPHA, 33'd32768);
        send_request(REQ_SAMPLE, 32'hFFFF_F000);
    endtask

    // Each scale factor at zero disables the update on its own.
    task automatic test_disabled_settings();
        write_reg(CFG_ENCODER_LINES, 33'd0);
        send_request(REQ_SAMPLE, 32'd77);
        write_reg(CFG_ENCODER_LINES, 33'd1);
        write_reg(CFG_GEAR_RATIO, 33'd0);
        send_request(REQ_SAMPLE, 32'd78);
        write_reg(CFG_GEAR_RATIO, 33'd1);
        write_reg(CFG_EDGE_MODE, 33'd0);
        send_request(REQ_SAMPLE, 32'd79);
        write_reg(CFG_EDGE_MODE, 33'd2);
        write_reg(CFG_SAMPLE_MS, 33'd0);
        send_request(REQ_SAMPLE, 32'd80);
    endtask

    // Next count: mostly a short walk from the last one, some long jumps inside the
    // period, a little noise anywhere in 32 bits, and rare clears.
    task automatic send_random_request();
        int          roll, step;
        longint      per, v;
        logic [31:0] cnt;
        roll = $urandom_range(0, 99);
        per  = longint'(period_sh);
        if (roll < 3) begin
            send_request(REQ_CLEAR, $urandom);
        end else begin
            if (per == 0 || roll >= 92) begin
                cnt = $urandom;
            end else if (roll < 65) begin
                step = int'($urandom_range(0, 4000)) - 2000;
                v = (longint'(last_count) + step) % per;
                if (v < 0)
                    v = v + per;
                cnt = v[31:0];
            end else begin
                v   = longint'({$urandom}) % per;
                cnt = v[31:0];
            end
            send_request(REQ_SAMPLE, cnt);
        end
    endtask

    task automatic test_random_traffic();
        logic [32:0] per;
        logic [30:0] step;
        logic [16:0] alpha;
        int          lines, ratio, edges, ms;
        for (int phase = 0; phase < 9; phase++) begin
            // first two settings run with no idling on either side
            tx_idle_pct = (phase < 2) ? 0 : IDLE_PCT;
            rx_idle_pct = (phase < 2) ? 0 : IDLE_PCT;
            if (phase == 0) begin
                write_setup(33'd2, 1'b0, 1, 1, 1, 1, 31'd1, 17'd0);
            end else if (phase == 1) begin
                write_setup(33'h1_0000_0000, 1'b1, 65535, 65535, 4, 65535,
                            31'h7FFF_FFFF, 17'd65536);
            end else begin
                case ($urandom_range(0, 5))
                    0: per = 33'd3;
                    1: per = 33'($urandom_range(4, 1000));
                    2: per = 33'd65536;
                    3: per = 33'($urandom_range(2, 65536));
                    4: per = {1'b0, $urandom} | 33'd2;
                    default: per = 33'h1_0000_0000;
                endcase
                case ($urandom_range(0, 3))
                    0: lines = 1;
                    1: lines = 65535;
                    default: lines = $urandom_range(1, 2048);
                endcase
                case ($urandom_range(0, 3))
                    0: ratio = 1;
                    1: ratio = 65535;
                    default: ratio = $urandom_range(1, 100);
                endcase
                case ($urandom_range(0, 3))
                    0: edges = 1;
                    1: edges = 2;
                    2: edges = 3;
                    default: edges = 4;
                endcase
                case ($urandom_range(0, 3))
                    0: ms = 1;
                    1: ms = 65535;
                    default: ms = $urandom_range(1, 100);
                endcase
                case ($urandom_range(0, 5))
                    0, 1: step = '0;
                    2: step = 31'd1;
                    3: step = 31'h7FFF_FFFF;
                    default: step = 31'($urandom_range(1, 100000));
                endcase
                case ($urandom_range(0, 5))
                    0: alpha = 17'd65536;
                    1: alpha = 17'd0;
                    2: alpha = 17'($urandom_range(65537, 131071));
                    default: alpha = 17'($urandom_range(0, 65536));
                endcase
                // last setting leaves the scale at zero for a short stretch
                if (phase == 8)
                    edges = 0;
                write_setup(per, 1'($urandom), lines, ratio, edges, ms, step, alpha);
            end
            for (int i = 0; i < ((phase == 8) ? 20 : PHASE_ITEMS); i++)
                send_random_request();
        end
    endtask

    //----------------------------------------------------------------------------------------
    // Main sequence
    //----------------------------------------------------------------------------------------

    initial begin
        // shadow registers and state at their reset values
        period_sh    = PERIOD_RST;
        reverse_sh   = 1'b0;
        lines_sh     = '0;
        ratio_sh     = '0;
        edges_sh     = '0;
        sample_ms_sh = SAMPLE_MS_RST;
        max_step_sh  = '0;
        alpha_sh     = ALPHA_ONE;
        last_count   = '0;
        pos_total    = '0;
        speed_est    = '0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_count_folding();
        test_odd_periods();
        test_speed_limits();
        test_disabled_settings();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d requests (%0d clears) over %0d register settings",
                 requests_sent, clears_sent, settings_used);
        $display("checked %0d results, %0d mismatches, %0d never arrived",
                 results_seen, mismatches, pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
